@@ src/cil_pkg.sv @@
// ----------------------------------------------------------------------------
// cil_pkg
// Shared types and constants for the column iso-level interpolator: the kind
// of job passed from the front end to the back end and the register indexes.
// ----------------------------------------------------------------------------
package cil_pkg;

  // Kind of job the front end hands to the back end.
  typedef enum logic {
    JOB_DIRECT = 1'b0,
    JOB_INTERP = 1'b1
  } job_kind_t;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_ISO_VALUE     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MISSING_VALUE = 1'b1;

endpackage

@@ src/cil_front.sv @@
// ----------------------------------------------------------------------------
// cil_front
// Accepts the samples of each column, checks adjacent pairs against the iso
// value until the first crossing and, on the last sample, issues one job:
// a ready level (or missing flag) or the operands of one interpolation.
// ----------------------------------------------------------------------------
module cil_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [cil_pkg::CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [VALUE_WIDTH-1:0]                 cfg_wdata,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,
  input  logic                                   s_tlast,
  output logic                                   job_valid,
  input  logic                                   job_ready,
  output logic [4*VALUE_WIDTH+2:0]               job_data
);
  import cil_pkg::*;

  localparam int W = VALUE_WIDTH;

  // Configuration registers.
  logic signed [W-1:0] iso_value;
  logic signed [W-1:0] missing_value;

  // Column state.
  logic signed [W-1:0] prev_sample;
  logic signed [W-1:0] prev_level;
  logic                prev_missing;
  logic                column_start;
  logic                crossing_found, crossing_found_next;
  logic [W-1:0]        held_level, held_level_next;
  logic                held_valid, held_valid_next;
  logic                pend_interp, pend_interp_next;
  logic                pend_dir, pend_dir_next;
  logic [W-1:0]        pend_dy, pend_dy_next;
  logic [W-1:0]        pend_num, pend_num_next;
  logic [W-1:0]        pend_den, pend_den_next;

  logic signed [W-1:0] cur_sample;
  logic signed [W-1:0] cur_level;
  logic                cur_missing;
  logic                accept;
  logic                between;
  job_kind_t           job_kind;
  logic                job_missing;
  logic [W-1:0]        job_value;

  // Magnitude of a signed difference; always fits in W unsigned bits.
  function automatic logic [W-1:0] abs_diff(input logic signed [W-1:0] a,
                                            input logic signed [W-1:0] b);
    logic [W-1:0] d_ab;
    logic [W-1:0] d_ba;
    d_ab = a - b;
    d_ba = b - a;
    return (a >= b) ? d_ab : d_ba;
  endfunction

  assign cur_sample  = s_tdata[W-1:0];
  assign cur_level   = s_tdata[2*W-1:W];
  assign cur_missing = (cur_sample == missing_value);
  assign s_tready    = job_ready;
  assign accept      = s_tvalid && s_tready;

  assign between = ((iso_value >= prev_sample) && (iso_value <= cur_sample)) ||
                   ((iso_value >= cur_sample) && (iso_value <= prev_sample));

  // Pair check against the previous sample.
  always_comb begin
    crossing_found_next = crossing_found;
    held_level_next     = held_level;
    held_valid_next     = held_valid;
    pend_interp_next    = pend_interp;
    pend_dir_next       = pend_dir;
    pend_dy_next        = pend_dy;
    pend_num_next       = pend_num;
    pend_den_next       = pend_den;
    if (column_start) begin
      crossing_found_next = 1'b0;
      held_valid_next     = 1'b0;
      held_level_next     = '0;
      pend_interp_next    = 1'b0;
    end else if (!crossing_found) begin
      if (prev_missing != cur_missing) begin
        // One sample missing: the other one may sit exactly on the iso value.
        if (prev_missing && (iso_value == cur_sample)) begin
          held_level_next = cur_level;
          held_valid_next = 1'b1;
        end
        if (cur_missing && (iso_value == prev_sample)) begin
          held_level_next = prev_level;
          held_valid_next = 1'b1;
        end
      end else if (!prev_missing && between) begin
        crossing_found_next = 1'b1;
        held_valid_next     = 1'b1;
        held_level_next     = prev_level;
        if (prev_sample != cur_sample) begin
          pend_interp_next = 1'b1;
          pend_dir_next    = (cur_level >= prev_level);
          pend_dy_next     = abs_diff(cur_level, prev_level);
          pend_num_next    = abs_diff(iso_value, prev_sample);
          pend_den_next    = abs_diff(cur_sample, prev_sample);
        end
      end
    end
  end

  // Job issued on the last sample of a column.
  always_comb begin
    if (held_valid_next) begin
      job_kind    = pend_interp_next ? JOB_INTERP : JOB_DIRECT;
      job_missing = 1'b0;
      job_value   = held_level_next;
    end else begin
      job_kind    = JOB_DIRECT;
      job_missing = 1'b1;
      job_value   = missing_value;
    end
  end

  assign job_valid = accept && s_tlast;
  assign job_data  = {job_kind, job_missing, pend_dir_next, job_value,
                      pend_dy_next, pend_num_next, pend_den_next};

  // Configuration and column state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      iso_value      <= '0;
      missing_value  <= {1'b1, {(W-1){1'b0}}};
      column_start   <= 1'b1;
      crossing_found <= 1'b0;
      held_valid     <= 1'b0;
      pend_interp    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_ISO_VALUE:     iso_value <= cfg_wdata;
          REG_MISSING_VALUE: missing_value <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        prev_sample    <= cur_sample;
        prev_level     <= cur_level;
        prev_missing   <= cur_missing;
        column_start   <= s_tlast;
        crossing_found <= crossing_found_next;
        held_level     <= held_level_next;
        held_valid     <= held_valid_next;
        pend_interp    <= pend_interp_next;
        pend_dir       <= pend_dir_next;
        pend_dy        <= pend_dy_next;
        pend_num       <= pend_num_next;
        pend_den       <= pend_den_next;
      end
    end
  end

  // A found crossing always leaves a held level, and only a crossing
  // leaves an interpolation pending.
  a_crossing_held: assert property (@(posedge clk) disable iff (rst)
    crossing_found |-> held_valid)
    else $error("crossing found without a held level");
  a_interp_crossing: assert property (@(posedge clk) disable iff (rst)
    pend_interp |-> crossing_found)
    else $error("interpolation pending without a crossing");

endmodule

@@ src/cil_queue.sv @@
// ----------------------------------------------------------------------------
// cil_queue
// Short job queue between the front end and the back end, built from
// registers with a read and a write pointer.
// ----------------------------------------------------------------------------
module cil_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Storage: no reset needed for the entries.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_count_pop: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on a pop");

endmodule

@@ src/cil_back.sv @@
// ----------------------------------------------------------------------------
// cil_back
// Carries out the jobs from the queue. A ready level goes straight to the
// output register; an interpolation runs a shift-add multiply and a
// restoring divide, one bit per cycle each, rounds, and adds the offset.
// ----------------------------------------------------------------------------
module cil_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 job_valid,
  output logic                                 job_ready,
  input  logic [4*VALUE_WIDTH+2:0]             job_data,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((VALUE_WIDTH+1+7)/8)*8-1:0]   m_tdata
);
  import cil_pkg::*;

  localparam int W      = VALUE_WIDTH;
  localparam int JOB_W  = 4 * W + 3;
  localparam int M_W    = ((W + 1 + 7) / 8) * 8;
  localparam int STEP_W = $clog2(W);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_RND, S_FIN} state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [W-1:0]      mcand;
  logic [W-1:0]      prod_hi;
  logic [W-1:0]      prod_lo;
  logic [W-1:0]      den;
  logic [W-1:0]      base;
  logic              dir;
  logic [W-1:0]      out_level;
  logic              out_missing;

  job_kind_t         job_kind;
  logic              job_missing;
  logic              job_dir;
  logic [W-1:0]      job_value;
  logic [W-1:0]      job_dy;
  logic [W-1:0]      job_num;
  logic [W-1:0]      job_den;
  logic              slot_free;
  logic              out_load;
  logic [W:0]        mul_sum;
  logic [W:0]        div_trial;
  logic              div_ge;
  logic [W:0]        div_rem;
  logic              round_up;
  logic [W-1:0]      fin_level;

  // Job fields.
  assign job_kind    = job_kind_t'(job_data[JOB_W-1]);
  assign job_missing = job_data[JOB_W-2];
  assign job_dir     = job_data[JOB_W-3];
  assign job_value   = job_data[4*W-1:3*W];
  assign job_dy      = job_data[3*W-1:2*W];
  assign job_num     = job_data[2*W-1:W];
  assign job_den     = job_data[W-1:0];

  assign slot_free = !m_tvalid || m_tready;
  assign job_ready = (state == S_IDLE) && ((job_kind == JOB_INTERP) || slot_free);

  // The output register takes a direct job or a finished interpolation.
  assign out_load = ((state == S_IDLE) && job_valid && job_ready &&
                     (job_kind == JOB_DIRECT)) ||
                    ((state == S_FIN) && slot_free);

  // Datapath of the multiply, divide, round and final add steps.
  assign mul_sum   = {1'b0, prod_hi} + (prod_lo[0] ? {1'b0, mcand} : {(W+1){1'b0}});
  assign div_trial = {prod_hi, prod_lo[W-1]};
  assign div_ge    = (div_trial >= {1'b0, den});
  assign div_rem   = div_ge ? (div_trial - {1'b0, den}) : div_trial;
  assign round_up  = ({prod_hi, 1'b0} >= {1'b0, den});
  assign fin_level = dir ? (base + prod_lo) : (base - prod_lo);

  assign m_tdata = M_W'({out_missing, out_level});

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            if (job_kind == JOB_INTERP) begin
              mcand   <= job_dy;
              prod_hi <= '0;
              prod_lo <= job_num;
              den     <= job_den;
              base    <= job_value;
              dir     <= job_dir;
              step    <= STEP_W'(W - 1);
              state   <= S_MUL;
            end else begin
              out_level   <= job_value;
              out_missing <= job_missing;
            end
          end
        end
        S_MUL: begin
          // One multiplier bit per cycle, least significant first.
          prod_hi <= mul_sum[W:1];
          prod_lo <= {mul_sum[0], prod_lo[W-1:1]};
          if (step == '0) begin
            step  <= STEP_W'(W - 1);
            state <= S_DIV;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_DIV: begin
          // One quotient bit per cycle; the quotient shifts into prod_lo.
          prod_hi <= div_rem[W-1:0];
          prod_lo <= {prod_lo[W-2:0], div_ge};
          if (step == '0) begin
            state <= S_RND;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_RND: begin
          // Round half away from the previous sample's level.
          prod_lo <= prod_lo + W'(round_up);
          state   <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            out_level   <= fin_level;
            out_missing <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The partial remainder stays below the divisor, and the offset never
  // exceeds the level span.
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (prod_hi < den))
    else $error("partial remainder not below divisor");
  a_offset_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (prod_lo <= mcand))
    else $error("offset exceeds level span");

endmodule

@@ src/column_isolevel_interpolator.sv @@
// ----------------------------------------------------------------------------
// column_isolevel_interpolator
// Finds, per vertical column, the level at which the field first reaches
// the iso value, by linear interpolation over adjacent samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples stream in on s_* one per transaction in level order; s_tlast
//   marks the last sample of a column. Each column yields one transaction
//   on m_*: the level found, or the missing flag with missing_value.
//   Registers are written over cfg_we / cfg_addr / cfg_wdata (index 0 is
//   iso_value, index 1 is missing_value) and act on later pairs at once.
// Throughput:
//   The front end takes one sample per cycle while the job queue has room.
//   A column without an interpolation passes through the job queue and the
//   output register. An interpolating column occupies the back end for a
//   multiply and a divide, a bit per cycle each, a rounding step and the
//   load of the output. Up to QUEUE_DEPTH finished columns wait in the job
//   queue; when it is full, s_tready drops until the back end takes a job.
// Reset and stalls:
//   rst (synchronous) empties the queue, returns iso_value to 0 and
//   missing_value to the most negative value, and opens a new column.
//   While m_tready is low the result holds and the back end waits at the
//   output load; the front end keeps accepting samples until the queue fills.
// ----------------------------------------------------------------------------
module column_isolevel_interpolator #(
  parameter int VALUE_WIDTH = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [cil_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [VALUE_WIDTH-1:0]               cfg_wdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // Fields from bit 0: sample_value, level_coord, zero fill.
  input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]   s_tdata,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // Fields from bit 0: surface_level, surface_missing, zero fill.
  output logic [((VALUE_WIDTH+1+7)/8)*8-1:0]   m_tdata
);

  localparam int JOB_W = 4 * VALUE_WIDTH + 3;

  logic             job_valid;
  logic             job_ready;
  logic [JOB_W-1:0] job_data;
  logic             q_valid;
  logic             q_ready;
  logic [JOB_W-1:0] q_data;

  // Front end: pair checks and job building.
  cil_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_data  (job_data)
  );

  // Job queue between the two halves.
  cil_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (job_valid),
    .in_ready  (job_ready),
    .in_data   (job_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  // Back end: interpolation and result register.
  cil_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job_data  (q_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // A finished column is never offered to a full queue.
  a_job_taken: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job_ready)
    else $error("column job dropped at the queue");
  a_ready_follows_queue: assert property (@(posedge clk) disable iff (rst)
    s_tready == job_ready)
    else $error("input ready out of step with queue space");

endmodule

@@ bench/tb_column_isolevel_interpolator.sv @@
// ----------------------------------------------------------------------------
// tb_column_isolevel_interpolator
// Self-checking bench for the column iso-level interpolator. It streams
// columns of samples through the slave port with random gaps and stalls the
// master port at random. Each accepted sample runs through a local column
// tracker that predicts the surface level of the column. Each result
// transaction is compared with the oldest prediction. A short table of
// hand-made columns comes first, followed by random phases, each opening
// with new register settings.
// ----------------------------------------------------------------------------
module tb_column_isolevel_interpolator;
  import cil_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = 32;
  localparam int NPROBE = 23;
  localparam int NPHASE = 10;
  localparam int PHASE_ITEMS = 95;
  localparam int SETTLE = 2 * VW + 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};

  // One result of the block: the level found and the missing flag.
  typedef struct packed {
    logic [VW-1:0] level;
    logic          miss;
  } surface_t;

  // One row of the hand-made table; fixed rows carry a typed-in result.
  typedef struct {
    logic [VW-1:0] sample;
    logic [VW-1:0] level;
    logic          last;
    bit            fixed;
    logic [VW-1:0] exp_level;
    logic          exp_miss;
  } probe_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [VW-1:0]         cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [2*VW-1:0]       s_tdata;   // Fields from bit 0: sample_value, level_coord.
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [VW+7:0]         m_tdata;   // Fields from bit 0: surface_level, surface_missing, zero fill.

  // Local copy of the registers and the column state.
  logic signed [VW-1:0] iso_reg;
  logic signed [VW-1:0] miss_reg;
  logic signed [VW-1:0] prev_val;
  logic signed [VW-1:0] prev_lvl;
  logic                 prev_miss;
  logic                 col_open;
  logic                 crossed;
  logic signed [VW-1:0] held_lvl;
  logic                 held_ok;

  surface_t   expected_surfaces[$];
  probe_row_t probes[NPROBE];
  int         failures = 0;
  int         cycle_count = 0;
  bit         steady = 1'b0;

  column_isolevel_interpolator #(
    .VALUE_WIDTH(VW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Idle length for either side: mostly none, sometimes short, rarely long.
  function automatic int pick_idle();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Distance between two signed values, without overflow.
  function automatic longint unsigned span(input logic signed [VW-1:0] a,
                                           input logic signed [VW-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? longint'(-d) : d;
  endfunction

  // Sends one sample, then advances the column tracker once it is taken.
  task automatic push_sample(input logic signed [VW-1:0] sample,
                             input logic signed [VW-1:0] level,
                             input logic last, input bit fixed,
                             input logic [VW-1:0] fixed_level,
                             input logic fixed_miss);
    int gap;
    logic miss_now;
    longint unsigned dy, num, den, prod, off, rem;
    surface_t nxt;
    gap = pick_idle();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {level, sample};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);

    // The first sample of a column only opens it; later ones close a pair.
    miss_now = (sample == miss_reg);
    if (col_open) begin
      crossed = 1'b0;
      held_ok = 1'b0;
      held_lvl = '0;
      col_open = 1'b0;
    end else if (!crossed) begin
      if (prev_miss && miss_now) begin
        // A pair of two missing samples says nothing.
      end else if (prev_miss || miss_now) begin
        // A missing neighbor of an exact hit keeps that hit's level.
        if (prev_miss && sample == iso_reg) begin
          held_lvl = level;
          held_ok = 1'b1;
        end
        if (miss_now && prev_val == iso_reg) begin
          held_lvl = prev_lvl;
          held_ok = 1'b1;
        end
      end else if ((iso_reg >= prev_val && iso_reg <= sample) ||
                   (iso_reg >= sample && iso_reg <= prev_val)) begin
        crossed = 1'b1;
        held_ok = 1'b1;
        if (prev_val == sample) begin
          held_lvl = prev_lvl;
        end else begin
          // Offset from the lower sample's level, rounded half away from it.
          dy = span(level, prev_lvl);
          num = span(iso_reg, prev_val);
          den = span(sample, prev_val);
          prod = dy * num;
          off = prod / den;
          rem = prod % den;
          if (2 * rem >= den && off < dy) off++;
          held_lvl = (level >= prev_lvl) ? prev_lvl + VW'(off) : prev_lvl - VW'(off);
        end
      end
    end
    prev_val = sample;
    prev_lvl = level;
    prev_miss = miss_now;

    if (last) begin
      col_open = 1'b1;
      if (fixed) begin
        nxt.level = fixed_level;
        nxt.miss = fixed_miss;
      end else if (held_ok) begin
        nxt.level = held_lvl;
        nxt.miss = 1'b0;
      end else begin
        nxt.level = miss_reg;
        nxt.miss = 1'b1;
      end
      expected_surfaces.push_back(nxt);
    end
  endtask

  // Lets every pending column come out, then lets the back end settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_surfaces.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Result side: random back-pressure.
  initial begin
    int gap;
    m_tready = 1'b0;
    forever begin
      gap = pick_idle();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    surface_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_surfaces.size() == 0) begin
        $error("result transaction with no column pending: %h", m_tdata);
        failures++;
      end else begin
        want = expected_surfaces.pop_front();
        if (m_tdata[VW-1:0] !== want.level) begin
          $error("surface_level expected %h, got %h", want.level, m_tdata[VW-1:0]);
          failures++;
        end
        if (m_tdata[VW] !== want.miss) begin
          $error("surface_missing expected %b, got %b", want.miss, m_tdata[VW]);
          failures++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    int sent;
    int len;
    int pick;
    bit down;
    logic signed [VW-1:0] v, lv, last_v;
    logic [VW-1:0] iso_w, miss_w;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = REG_ISO_VALUE;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    iso_reg = '0;
    miss_reg = VMIN;
    prev_val = '0;
    prev_lvl = '0;
    prev_miss = 1'b0;
    col_open = 1'b1;
    crossed = 1'b0;
    held_lvl = '0;
    held_ok = 1'b0;

    // Hand-made columns, run with the reset register values.
    probes = '{
      // A column of one sample has no pair.
      '{32'h0005_0000, 32'h0000_0000, 1'b1, 1'b1, VMIN, 1'b1},
      // Symmetric crossing lands halfway.
      '{32'hFFFF_0000, 32'h0000_0000, 1'b0, 1'b0, '0, 1'b0},
      '{32'h0001_0000, 32'h0064_0000, 1'b1, 1'b1, 32'h0032_0000, 1'b0},
      // Two equal samples on the iso value give the lower level.
      '{32'h0000_0000, 32'h000A_0000, 1'b0, 1'b0, '0, 1'b0},
      '{32'h0000_0000, 32'h0014_0000, 1'b1, 1'b1, 32'h000A_0000, 1'b0},
      // Hits next to missing samples; the latest one wins.
      '{VMIN,          32'h0000_0005, 1'b0, 1'b0, '0, 1'b0},
      '{32'h0000_0000, 32'h0000_0007, 1'b0, 1'b0, '0, 1'b0},
      '{VMIN,          32'h0000_0009, 1'b0, 1'b0, '0, 1'b0},
      '{32'h0000_0000, 32'h0000_000B, 1'b1, 1'b1, 32'h0000_000B, 1'b0},
      // Both samples missing.
      '{VMIN,          32'h0000_0001, 1'b0, 1'b0, '0, 1'b0},
      '{VMIN,          32'h0000_0002, 1'b1, 1'b1, VMIN, 1'b1},
      // The first crossing ends the search.
      '{32'hFFFF_FFFE, 32'h0000_0100, 1'b0, 1'b0, '0, 1'b0},
      '{32'h0000_0002, 32'h0000_0300, 1'b0, 1'b0, '0, 1'b0},
      '{32'hFFFF_FFFB, 32'h0000_0999, 1'b0, 1'b0, '0, 1'b0},
      '{32'h0000_0005, 32'h0000_0777, 1'b1, 1'b1, 32'h0000_0200, 1'b0},
      // Full-scale samples and levels.
      '{32'h8000_0001, VMIN,          1'b0, 1'b0, '0, 1'b0},
      '{VMAX,          VMAX,          1'b1, 1'b0, '0, 1'b0},
      // Falling levels.
      '{32'h0000_0003, 32'h0000_0500, 1'b0, 1'b0, '0, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0100, 1'b1, 1'b0, '0, 1'b0},
      // No crossing and no hit.
      '{32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, '0, 1'b0},
      '{32'h0000_0003, 32'h0000_0000, 1'b1, 1'b1, VMIN, 1'b1},
      // Offset of exactly one half.
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, '0, 1'b0},
      '{32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0, '0, 1'b0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probes[i])
      push_sample(probes[i].sample, probes[i].level, probes[i].last,
                  probes[i].fixed, probes[i].exp_level, probes[i].exp_miss);
    drain();

    // Random phases, each with its own register settings.
    for (int p = 0; p < NPHASE; p++) begin
      case (p)
        0: begin iso_w = VMAX; miss_w = VMIN; end
        1: begin iso_w = VMIN; miss_w = VMAX; end
        2: begin iso_w = 32'h0001_0000; miss_w = '0; end
        3: begin iso_w = '0; miss_w = VMIN; end
        default: begin
          iso_w = ($urandom_range(0, 1) == 1) ? $urandom
                                              : VW'($urandom_range(0, 32'h000A_0000));
          miss_w = $urandom;
        end
      endcase
      cfg_we <= 1'b1;
      cfg_addr <= REG_ISO_VALUE;
      cfg_wdata <= iso_w;
      @(posedge clk);
      iso_reg = iso_w;
      cfg_addr <= REG_MISSING_VALUE;
      cfg_wdata <= miss_w;
      @(posedge clk);
      miss_reg = miss_w;
      cfg_we <= 1'b0;
      steady = ($urandom_range(0, 3) == 0);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Mostly short columns, a few single samples and a few long ones.
        pick = $urandom_range(0, 9);
        len = (pick == 0) ? 1 : (pick == 1) ? $urandom_range(7, 24) : $urandom_range(2, 6);
        down = $urandom_range(0, 1);
        lv = $urandom;
        last_v = $urandom;
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 20) v = iso_reg;
          else if (pick < 32) v = miss_reg;
          else if (pick < 42) v = last_v;
          else if (pick < 62) v = iso_reg + VW'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
          else if (pick < 70) v = ($urandom_range(0, 1) == 1) ? VMAX : VMIN;
          else v = $urandom;
          if ($urandom_range(0, 9) == 0) lv = $urandom;
          else if (down) lv = lv - VW'($urandom_range(0, 32'h3_0000));
          else lv = lv + VW'($urandom_range(0, 32'h3_0000));
          push_sample(v, lv, (k == len - 1), 1'b0, '0, 1'b0);
          last_v = v;
          sent++;
        end
      end
      drain();
    end

    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
